[hw/rtl/custom_float_add_mul_convert_assert.svh]
// Assertion macros shared by the float unit RTL
`ifndef CUSTOM_FLOAT_ADD_MUL_CONVERT_ASSERT_SVH
`define CUSTOM_FLOAT_ADD_MUL_CONVERT_ASSERT_SVH

// Implication checked on every rising clock edge outside reset
`define CFAM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset
`define CFAM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/cfam_pkg.sv]
// ----------------------------------------------------------------------------
// cfam_pkg
// Shared codes and constants for the custom float add / multiply / convert unit.
// ----------------------------------------------------------------------------
package cfam_pkg;

	localparam logic [1:0] MODE_CONV = 2'd0;
	localparam logic [1:0] MODE_ADD  = 2'd1;
	localparam logic [1:0] MODE_MUL  = 2'd2;
	localparam logic [1:0] MODE_BAD  = 2'd3;

	localparam int IEEE_MANT_BITS = 23;
	localparam int IEEE_EXP_BITS  = 8;
	localparam int IEEE_SIG_BITS  = 24;

endpackage

[hw/rtl/cfam_if.sv]
// ----------------------------------------------------------------------------
// cfam_in_if / cfam_out_if
// Valid/ready request channels carrying operands and results.
// ----------------------------------------------------------------------------
interface cfam_in_if #(
	parameter int SIG_W = 24,
	parameter int EXP_W = 11
);
	logic                    valid;
	logic                    ready;
	logic [1:0]              mode;
	logic [SIG_W-1:0]        a_v;
	logic signed [EXP_W-1:0] a_p;
	logic                    a_z;
	logic                    a_s;
	logic [SIG_W-1:0]        b_v;
	logic signed [EXP_W-1:0] b_p;
	logic                    b_z;
	logic                    b_s;
	logic [31:0]             float_bits;

	modport source (output valid, mode, a_v, a_p, a_z, a_s, b_v, b_p, b_z, b_s,
		float_bits, input ready);
	modport sink (input valid, mode, a_v, a_p, a_z, a_s, b_v, b_p, b_z, b_s,
		float_bits, output ready);
endinterface

interface cfam_out_if #(
	parameter int SIG_W = 24,
	parameter int EXP_W = 11
);
	logic                    valid;
	logic                    ready;
	logic [SIG_W:0]          r_v;
	logic signed [EXP_W-1:0] r_p;
	logic                    r_z;
	logic                    r_s;
	logic                    range_flag;

	modport source (output valid, r_v, r_p, r_z, r_s, range_flag, input ready);
	modport sink (input valid, r_v, r_p, r_z, r_s, range_flag, output ready);
endinterface

[hw/rtl/custom_float_add_mul_convert.sv]
// ----------------------------------------------------------------------------
// custom_float_add_mul_convert
// Pipelined convert / add / multiply unit for a (v, p, z, s) float format.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch (sink): one request per valid&ready edge, carrying mode, both
//    operands and the IEEE single bits used by convert mode.
//  - out_ch (source): one result per request, in request order.
//  - Pipeline: a request accepted on in_ch passes s1, s2, s3, s4 in turn.
//    s1 decodes/aligns (normalize search for denormals, operand swap),
//    s2 shifts / multiplies, s3 adds / sums exponents, s4 saturates.
//  - Throughput: one request per cycle unless out_ch stalls; the multiplier in s2 and the
//    add in s3 set the per-stage depth.
//  - Stall: all stages advance on a single enable (output free or
//    empty); bubbles move along with the pipe and are not squeezed out,
//    nothing is lost or repeated. ready is high whenever the pipe can advance.
//  - Reset (arst_n low): all valid bits clear; payload is left as is.
// ----------------------------------------------------------------------------
`include "custom_float_add_mul_convert_assert.svh"

module custom_float_add_mul_convert #(
	parameter int SIGNIFICAND_BITS = 24,
	parameter int EXPONENT_BITS    = 11
) (
	input logic clk,
	input logic arst_n,
	cfam_in_if.sink    in_ch,
	cfam_out_if.source out_ch
);
	localparam int SW = SIGNIFICAND_BITS;
	localparam int EW = EXPONENT_BITS;
	// internal exponent width: holds sums of two exponents plus SW
	localparam int IW = EW + 3;
	localparam int SHW = 7; // shift amount 0..64
	localparam logic signed [IW-1:0] EMAX = IW'((1 << (EW-1)) - 1);
	localparam logic signed [IW-1:0] EMIN = -EMAX - IW'(1);

	logic v1, v2, v3, v4;
	logic adv;
	// output stage advances when empty or taken; the whole pipe moves together
	assign adv = !v4 || out_ch.ready;
	assign in_ch.ready = adv;

	// ---------------- stage 1: decode ----------------
	logic [1:0]              mode_s1;
	logic [SW-1:0]           x_s1, y_s1;   // big / small (add) or a / b (mul)
	logic signed [IW-1:0]    px_s1, py_s1;
	logic                    sx_s1, sy_s1;
	logic [SHW-1:0]          sh_s1;
	logic                    zero_s1, pass_s1, inf_s1, sign_s1;

	logic [4:0]  lz;
	logic [22:0] man;
	logic [7:0]  iexp;
	logic [23:0] csig;
	logic signed [IW-1:0] cexp;
	logic signed [IW-1:0] pa, pb, dif;

	always_comb begin
		man  = in_ch.float_bits[22:0];
		iexp = in_ch.float_bits[30:23];
		lz = 5'd0;
		for (int i = 0; i < 23; i++) begin
			if (man[i]) lz = 5'(22 - i);
		end
		if (iexp != 8'd0) begin
			csig = {1'b1, man};
			cexp = IW'($signed({1'b0, iexp})) - IW'(150);
		end else begin
			csig = {man, 1'b0} << lz;
			cexp = IW'(-149) - IW'(lz) - IW'(1);
		end
		pa = IW'(in_ch.a_p);
		pb = IW'(in_ch.b_p);
		dif = (pa >= pb) ? pa - pb : pb - pa;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
		end else if (adv) begin
			v1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1 <= in_ch.mode;
			sh_s1   <= (dif >= IW'(64)) ? SHW'(64) : SHW'(dif);
			zero_s1 <= 1'b0;
			pass_s1 <= 1'b0;
			inf_s1  <= 1'b0;
			sign_s1 <= 1'b0;
			x_s1  <= in_ch.a_v;
			y_s1  <= in_ch.b_v;
			px_s1 <= pa;
			py_s1 <= pb;
			sx_s1 <= in_ch.a_s;
			sy_s1 <= in_ch.b_s;
			unique case (in_ch.mode)
				cfam_pkg::MODE_CONV: begin
					sign_s1 <= in_ch.float_bits[31];
					if (iexp == 8'hFF) begin
						inf_s1 <= 1'b1;
					end else if (iexp == 8'd0 && man == 23'd0) begin
						zero_s1 <= 1'b1;
					end
					if (SW >= cfam_pkg::IEEE_SIG_BITS) begin
						x_s1  <= SW'(csig) << (SW - cfam_pkg::IEEE_SIG_BITS);
						px_s1 <= cexp - IW'(SW - cfam_pkg::IEEE_SIG_BITS);
					end else begin
						x_s1  <= SW'(csig >> (cfam_pkg::IEEE_SIG_BITS - SW));
						px_s1 <= cexp + IW'(cfam_pkg::IEEE_SIG_BITS - SW);
					end
				end
				cfam_pkg::MODE_ADD: begin
					if (in_ch.a_z && in_ch.b_z) begin
						zero_s1 <= 1'b1;
					end else if (in_ch.a_z || in_ch.b_z) begin
						pass_s1 <= 1'b1;
					end
					if (in_ch.a_z || (!in_ch.b_z && pa < pb)) begin
						x_s1  <= in_ch.b_v;
						px_s1 <= pb;
						sx_s1 <= in_ch.b_s;
						y_s1  <= in_ch.a_v;
						sy_s1 <= in_ch.a_s;
					end
				end
				cfam_pkg::MODE_MUL: begin
					zero_s1 <= in_ch.a_z | in_ch.b_z;
				end
				default: begin
					zero_s1 <= 1'b1;
				end
			endcase
		end
	end

	// ---------------- stage 2: shift / multiply ----------------
	logic [1:0]           mode_s2;
	logic [SW-1:0]        x_s2, y_s2;
	logic [2*SW-1:0]      prod_s2;
	logic signed [IW-1:0] px_s2, py_s2;
	logic                 sx_s2, sy_s2, zero_s2, pass_s2, inf_s2, sign_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2 <= 1'b0;
		end else if (adv) begin
			v2 <= v1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s2 <= mode_s1;
			x_s2  <= x_s1;
			y_s2  <= (pass_s1 || sh_s1 >= SHW'(SW)) ? (pass_s1 ? y_s1 : '0)
				: (y_s1 >> sh_s1);
			prod_s2 <= (2*SW)'(x_s1) * (2*SW)'(y_s1);
			px_s2 <= px_s1;
			py_s2 <= py_s1;
			sx_s2 <= sx_s1;
			sy_s2 <= sy_s1;
			zero_s2 <= zero_s1;
			pass_s2 <= pass_s1;
			inf_s2  <= inf_s1;
			sign_s2 <= sign_s1;
		end
	end

	// ---------------- stage 3: add / exponent sum ----------------
	logic [SW:0]          rv_s3;
	logic signed [IW-1:0] rp_s3;
	logic                 rz_s3, rs_s3, inf_s3, sat_s3;
	logic signed [SW+1:0] sum;

	always_comb begin
		sum = (sx_s2 ? -$signed({2'b0, x_s2}) : $signed({2'b0, x_s2}))
			+ (sy_s2 ? -$signed({2'b0, y_s2}) : $signed({2'b0, y_s2}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v3 <= 1'b0;
		end else if (adv) begin
			v3 <= v2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rz_s3  <= zero_s2;
			inf_s3 <= inf_s2;
			sat_s3 <= 1'b0;
			rs_s3  <= 1'b0;
			rv_s3  <= '0;
			rp_s3  <= '0;
			unique case (mode_s2)
				cfam_pkg::MODE_CONV: begin
					rv_s3  <= (SW+1)'(x_s2);
					rp_s3  <= px_s2;
					rs_s3  <= sign_s2;
					sat_s3 <= 1'b1;
				end
				cfam_pkg::MODE_ADD: begin
					if (pass_s2) begin
						rv_s3 <= (SW+1)'(x_s2);
						rs_s3 <= sx_s2;
						rp_s3 <= px_s2;
					end else begin
						rz_s3 <= zero_s2 || (sum == '0);
						rs_s3 <= sum[SW+1];
						rv_s3 <= (SW+1)'(sum[SW+1] ? -sum : sum);
						rp_s3 <= px_s2;
					end
				end
				cfam_pkg::MODE_MUL: begin
					rv_s3  <= (SW+1)'(prod_s2 >> SW);
					rp_s3  <= px_s2 + py_s2 + IW'(SW);
					rs_s3  <= sx_s2 ^ sy_s2;
					sat_s3 <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// undefined mode tracked alongside s3
	logic mode_s3_bad;
	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s3_bad <= (mode_s2 == cfam_pkg::MODE_BAD);
		end
	end

	// ---------------- stage 4: saturate / output register ----------------
	logic [SW:0]          rv_s4;
	logic signed [EW-1:0] rp_s4;
	logic                 rz_s4, rs_s4, fl_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4 <= 1'b0;
		end else if (adv) begin
			v4 <= v3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rv_s4 <= rv_s3;
			rp_s4 <= EW'(rp_s3);
			rs_s4 <= rs_s3;
			rz_s4 <= 1'b0;
			fl_s4 <= 1'b0;
			if (inf_s3) begin
				rv_s4 <= (SW+1)'({SW{1'b1}});
				rp_s4 <= EW'(EMAX);
				fl_s4 <= 1'b1;
			end else if (rz_s3) begin
				rv_s4 <= '0;
				rp_s4 <= '0;
				rs_s4 <= 1'b0;
				rz_s4 <= 1'b1;
				fl_s4 <= (mode_s3_bad);
			end else if (sat_s3 && rp_s3 > EMAX) begin
				rv_s4 <= (SW+1)'({SW{1'b1}});
				rp_s4 <= EW'(EMAX);
				fl_s4 <= 1'b1;
			end else if (sat_s3 && rp_s3 < EMIN) begin
				rp_s4 <= EW'(EMIN);
				fl_s4 <= 1'b1;
			end
		end
	end

	assign out_ch.valid      = v4;
	assign out_ch.r_v        = rv_s4;
	assign out_ch.r_p        = rp_s4;
	assign out_ch.r_z        = rz_s4;
	assign out_ch.r_s        = rs_s4;
	assign out_ch.range_flag = fl_s4;

	`CFAM_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.r_v), "stalled result changed")
	`CFAM_ASSERT_IMP(a_zero, clk, arst_n, out_ch.valid && out_ch.r_z,
		out_ch.r_v == '0 && !out_ch.r_s, "zero result not canonical")
	`CFAM_ASSERT_IMP(a_rdy, clk, arst_n, !out_ch.valid, in_ch.ready,
		"pipe blocked with empty output")
endmodule
